[sv/gtbc_pkg.sv]
// Shared types, constants and helpers for the gyro temperature bias compensator.
`default_nettype none

package gtbc_pkg;

    // Default sizes of the temperature average and of the bias refresh interval
    localparam int AVG_LEN_DEF        = 16;
    localparam int REFRESH_PERIOD_DEF = 12;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SLOPE_X     = 3'd0,
        CFG_SLOPE_Y     = 3'd1,
        CFG_SLOPE_Z     = 3'd2,
        CFG_INTERCEPT_X = 3'd3,
        CFG_INTERCEPT_Y = 3'd4,
        CFG_INTERCEPT_Z = 3'd5
    } cfg_reg_t;

    // One sensor burst
    typedef struct packed {
        logic signed [15:0] temp_raw;
        logic signed [15:0] rate_x_raw;
        logic signed [15:0] rate_y_raw;
        logic signed [15:0] rate_z_raw;
    } burst_t;

    // One compensated result
    typedef struct packed {
        logic signed [23:0] filtered_temp;
        logic signed [31:0] rate_x_comp;
        logic signed [31:0] rate_y_comp;
        logic signed [31:0] rate_z_comp;
        logic               bias_refreshed;
    } comp_t;

    // Clamp a 34-bit signed value into the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -34'sh0_8000_0000)
        begin
            r = -32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/gyro_temperature_bias_compensator.sv]
// Top level: moving-average temperature filter, bias refresh and rate compensation.
`default_nettype none

// One burst in, one compensated result out, at up to one burst per clock while
// the output is not stalled. The burst is registered as it is taken, then
// passes the reciprocal multiply for the average, the bias multiply, and the
// bias add and clamp, and the rate subtract lands it in the output register:
// five stages in all. The stages drain into each other, so a burst is still
// taken while a finished result waits on a stalled output, as long as a stage
// is free. The temperature history sits in a RAM of AVG_LEN entries with one
// write port and one registered read port; no clearing pass is needed after
// reset, because entries not yet written since the first burst read as that
// first temperature. Biases are recomputed on the first burst after reset and
// then on every REFRESH_PERIOD-th burst. Configuration is to be written only
// while idle; the user is bound by this, as the block does not enforce it.
module gyro_temperature_bias_compensator
#(
    parameter int AVG_LEN        = gtbc_pkg::AVG_LEN_DEF,
    parameter int REFRESH_PERIOD = gtbc_pkg::REFRESH_PERIOD_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [31:0]     cfg_data,
    input  wire logic            burst_valid,
    output logic                 burst_stall,
    input  wire gtbc_pkg::burst_t burst,
    output logic                 comp_valid,
    input  wire logic            comp_stall,
    output gtbc_pkg::comp_t      comp
);
    import gtbc_pkg::*;

    localparam int IDX_W   = $clog2(AVG_LEN);
    localparam int SUM_W   = 16 + IDX_W;
    localparam int CNT_W   = (REFRESH_PERIOD > 1) ? $clog2(REFRESH_PERIOD) : 1;
    localparam int RSHIFT  = 32 + IDX_W;
    localparam int RECIP_W = 33;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int QSHIFT  = 24 + IDX_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RSHIFT) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN);
    localparam logic [RECIP_W-1:0]    RECIP      = RECIP_W'(RECIP_FULL);
    localparam logic [SUM_W-1:0]      SUM_OFFSET = SUM_W'(32768 * AVG_LEN);
    localparam logic signed [SUM_W-1:0] AVG_LEN_S = SUM_W'(AVG_LEN);
    localparam logic [IDX_W-1:0]      IDX_LAST   = IDX_W'(AVG_LEN - 1);
    localparam logic [CNT_W-1:0]      CNT_LAST   = CNT_W'(REFRESH_PERIOD - 1);

    // Configuration registers
    logic signed [31:0] slope_reg [3];
    logic signed [31:0] intercept_reg [3];

    // Filter and refresh state
    logic [15:0]              temp_hist_reg [AVG_LEN];
    logic signed [15:0]       hist_rd_reg;
    logic signed [15:0]       first_temp_reg;
    logic                     seen_first_reg;
    logic                     wrapped_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]         refresh_cnt_reg;
    logic signed [31:0]       bias_reg [3];

    // Pipeline stages
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic [SUM_W-1:0]         s1_off_reg;
    burst_t                   s1_burst_reg, s2_burst_reg, s3_burst_reg, s4_burst_reg;
    logic                     s1_refresh_reg, s2_refresh_reg, s3_refresh_reg, s4_refresh_reg;
    logic [PROD_W-1:0]        s2_prod_reg;
    logic signed [23:0]       s3_filt_reg, s4_filt_reg;
    logic signed [55:0]       s3_bprod_reg [3];
    comp_t                    comp_reg;

    // Combinational
    logic                     en1, en2, en3, en4, en5, accept;
    logic                     idx_is_last;
    logic [IDX_W-1:0]         idx_inc, rd_addr;
    logic signed [15:0]       old_temp;
    logic signed [SUM_W-1:0]  t_ext, old_ext, sum_next;
    logic [SUM_W-1:0]         off_next;
    logic [23:0]              quot;
    logic signed [23:0]       filt;
    logic signed [31:0]       bias_new [3];
    logic signed [23:0]       rate_x_s, rate_y_s, rate_z_s;
    comp_t                    comp_next;

    // Stage enables: a stage loads when empty or when its successor moves on
    assign en5    = !out_v_reg || !comp_stall;
    assign en4    = !v4_reg || en5;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign accept = burst_valid && en1;

    assign burst_stall = !en1;
    assign comp_valid  = out_v_reg;
    assign comp        = comp_reg;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                slope_reg[i]     <= '0;
                intercept_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SLOPE_X:     slope_reg[0]     <= cfg_data;
                CFG_SLOPE_Y:     slope_reg[1]     <= cfg_data;
                CFG_SLOPE_Z:     slope_reg[2]     <= cfg_data;
                CFG_INTERCEPT_X: intercept_reg[0] <= cfg_data;
                CFG_INTERCEPT_Y: intercept_reg[1] <= cfg_data;
                CFG_INTERCEPT_Z: intercept_reg[2] <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Running sum update; the first burst seeds the whole history
    always_comb
    begin
        idx_is_last = (idx_reg == IDX_LAST);
        idx_inc     = idx_is_last ? '0 : idx_reg + 1'b1;
        rd_addr     = accept ? idx_inc : idx_reg;
        old_temp    = wrapped_reg ? hist_rd_reg : first_temp_reg;
        t_ext       = SUM_W'(burst.temp_raw);
        old_ext     = SUM_W'(old_temp);
        if (!seen_first_reg)
        begin
            sum_next = t_ext * AVG_LEN_S;
        end
        else
        begin
            sum_next = sum_reg + t_ext - old_ext;
        end
        off_next = sum_next + SUM_OFFSET;
    end

    // History RAM: write the new sample, prefetch the entry due next
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_hist_reg[idx_reg] <= burst.temp_raw;
        end
        hist_rd_reg <= temp_hist_reg[rd_addr];
    end

    // Filter and refresh control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_reg  <= 1'b0;
            wrapped_reg     <= 1'b0;
            idx_reg         <= '0;
            sum_reg         <= '0;
            refresh_cnt_reg <= '0;
            first_temp_reg  <= '0;
        end
        else if (accept)
        begin
            seen_first_reg  <= 1'b1;
            wrapped_reg     <= wrapped_reg || idx_is_last;
            idx_reg         <= idx_inc;
            sum_reg         <= sum_next;
            refresh_cnt_reg <= (refresh_cnt_reg == CNT_LAST) ? '0 : refresh_cnt_reg + 1'b1;
            if (!seen_first_reg)
            begin
                first_temp_reg <= burst.temp_raw;
            end
        end
    end

    // Average quotient: offset sum times reciprocal, then drop the offset bit
    assign quot = s2_prod_reg[QSHIFT +: 24];
    assign filt = {~quot[23], quot[22:0]};

    // New biases: floor of product, plus intercept, clamped
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bias_new[i] = sat32(34'(s3_bprod_reg[i] >>> 24) + 34'(intercept_reg[i]));
        end
    end

    // Compensated rates, Z negated
    always_comb
    begin
        rate_x_s                 = {s4_burst_reg.rate_x_raw, 8'd0};
        rate_y_s                 = {s4_burst_reg.rate_y_raw, 8'd0};
        rate_z_s                 = {s4_burst_reg.rate_z_raw, 8'd0};
        comp_next.filtered_temp  = s4_filt_reg;
        comp_next.rate_x_comp    = sat32(34'(rate_x_s) - 34'(bias_reg[0]));
        comp_next.rate_y_comp    = sat32(34'(rate_y_s) - 34'(bias_reg[1]));
        comp_next.rate_z_comp    = sat32(-34'(rate_z_s) - 34'(bias_reg[2]));
        comp_next.bias_refreshed = s4_refresh_reg;
    end

    // Pipeline valids and bias state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                bias_reg[i] <= '0;
            end
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= burst_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
                if (v3_reg && s3_refresh_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        bias_reg[i] <= bias_new[i];
                    end
                end
            end
            if (en5)
            begin
                out_v_reg <= v4_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_off_reg     <= off_next;
            s1_burst_reg   <= burst;
            s1_refresh_reg <= (refresh_cnt_reg == '0);
        end
        if (en2)
        begin
            s2_prod_reg    <= PROD_W'(s1_off_reg) * PROD_W'(RECIP);
            s2_burst_reg   <= s1_burst_reg;
            s2_refresh_reg <= s1_refresh_reg;
        end
        if (en3)
        begin
            s3_filt_reg    <= filt;
            s3_burst_reg   <= s2_burst_reg;
            s3_refresh_reg <= s2_refresh_reg;
            for (int i = 0; i < 3; i++)
            begin
                s3_bprod_reg[i] <= slope_reg[i] * filt;
            end
        end
        if (en4)
        begin
            s4_filt_reg    <= s3_filt_reg;
            s4_burst_reg   <= s3_burst_reg;
            s4_refresh_reg <= s3_refresh_reg;
        end
        if (en5)
        begin
            comp_reg <= comp_next;
        end
    end

endmodule

`default_nettype wire

[sv/gtbc_checker.sv]
// Port-level checks for the gyro temperature bias compensator, bound to the top level.
`default_nettype none

module gtbc_checker
#(
    parameter int REFRESH_PERIOD = gtbc_pkg::REFRESH_PERIOD_DEF
)
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            burst_valid,
    input wire logic            burst_stall,
    input wire logic            comp_valid,
    input wire logic            comp_stall,
    input wire gtbc_pkg::comp_t comp
);
    import gtbc_pkg::*;

    localparam int CNT_W = (REFRESH_PERIOD > 1) ? $clog2(REFRESH_PERIOD) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REFRESH_PERIOD - 1);

    logic             in_beat, out_beat;
    logic [2:0]       inflight_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    assign in_beat  = burst_valid && !burst_stall;
    assign out_beat = comp_valid && !comp_stall;

    // Track bursts in flight and the place of each result in the refresh cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 3'(in_beat) - 3'(out_beat);
            if (out_beat)
            begin
                out_cnt_reg <= (out_cnt_reg == CNT_LAST) ? '0 : out_cnt_reg + 1'b1;
            end
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        comp_valid && comp_stall |=> comp_valid && $stable(comp))
        else $error("stalled result changed");

    // Biases refresh on the first result and then every refresh period
    a_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> comp.bias_refreshed == (out_cnt_reg == '0))
        else $error("bias refresh out of cadence");

    // No result without a burst, and no more than five in flight
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg <= 3'd5) && (!comp_valid || inflight_reg != 3'd0))
        else $error("burst and result counts disagree");

    // With the output empty, the pipeline always takes a burst
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !comp_valid |-> !burst_stall)
        else $error("input stalled with empty output");

endmodule

bind gyro_temperature_bias_compensator gtbc_checker
#(
    .REFRESH_PERIOD(REFRESH_PERIOD)
) u_gtbc_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .burst_valid(burst_valid),
    .burst_stall(burst_stall),
    .comp_valid(comp_valid),
    .comp_stall(comp_stall),
    .comp(comp)
);

`default_nettype wire

[test/tb_gyro_temperature_bias_compensator.sv]
// Self-checking testbench for the gyro temperature bias compensator.
module tb_gyro_temperature_bias_compensator;

    import gtbc_pkg::*;

    localparam int AVG        = AVG_LEN_DEF;
    localparam int PERIOD     = REFRESH_PERIOD_DEF;
    localparam int IDLE_PCT   = 23;
    localparam int STALL_LIMIT = 1000;
    localparam int QUIET_LO   = 260;
    localparam int QUIET_HI   = 340;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 90;
    localparam int RAND_ITEMS = 95;

    // Register indexes beyond the coefficient set; writes there are ignored
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        burst_valid = 1'b0;
    logic        burst_stall;
    burst_t      burst = '0;
    logic        comp_valid;
    logic        comp_stall = 1'b0;
    comp_t       comp;

    // Bursts waiting to be offered and compensated results still owed
    burst_t pending_bursts[$];
    comp_t  expected_comp[$];

    // Predictor state: coefficients, temperature history and biases
    longint slope_coef[3]  = '{0, 0, 0};
    longint offset_coef[3] = '{0, 0, 0};
    longint temp_hist[AVG];
    int     hist_pos = 0;
    longint temp_total = 0;
    bit     seen_first = 1'b0;
    int     refresh_cnt = 0;
    longint axis_bias[3] = '{0, 0, 0};

    bit  burst_taken = 1'b0;
    int  bursts_sent = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  refresh_total = 0;
    int  saturated_total = 0;
    int  coeff_sets = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  idle_cycles = 0;
    int  temp_walk = 0;

    gyro_temperature_bias_compensator uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .burst_valid (burst_valid),
        .burst_stall (burst_stall),
        .burst       (burst),
        .comp_valid  (comp_valid),
        .comp_stall  (comp_stall),
        .comp        (comp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clamp to the signed 32-bit range
    function automatic logic [31:0] clamp_word(input longint v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Advance the filter and bias state by one burst and form its result
    task automatic advance_compensation(input burst_t b, output comp_t res);
        longint     t;
        longint     rates[3];
        longint     num;
        longint     filt;
        logic [31:0] word;
        logic       refresh;
        int         k;
        t = longint'($signed(b.temp_raw));
        rates[0] = longint'($signed(b.rate_x_raw)) * 256;
        rates[1] = longint'($signed(b.rate_y_raw)) * 256;
        rates[2] = -(longint'($signed(b.rate_z_raw)) * 256);

        // Seed the whole history with the first temperature
        if (!seen_first)
        begin
            for (k = 0; k < AVG; k++)
            begin
                temp_hist[k] = t;
            end
            temp_total = t * AVG;
            hist_pos = 0;
            seen_first = 1'b1;
        end
        temp_total += t - temp_hist[hist_pos];
        temp_hist[hist_pos] = t;
        hist_pos = (hist_pos + 1) % AVG;

        // Average with floor rounding
        num = temp_total * 256;
        filt = num / AVG;
        if ((num % AVG) != 0 && num < 0)
        begin
            filt -= 1;
        end

        refresh = (refresh_cnt == 0);
        if (refresh)
        begin
            refresh_total++;
            for (k = 0; k < 3; k++)
            begin
                word = clamp_word(((slope_coef[k] * filt) >>> 24) + offset_coef[k]);
                axis_bias[k] = longint'($signed(word));
            end
        end
        refresh_cnt = (refresh_cnt + 1 >= PERIOD) ? 0 : refresh_cnt + 1;

        res.filtered_temp = filt[23:0];
        res.bias_refreshed = refresh;
        for (k = 0; k < 3; k++)
        begin
            word = clamp_word(rates[k] - axis_bias[k]);
            if (word == 32'h7FFF_FFFF || word == 32'h8000_0000)
            begin
                saturated_total++;
            end
            case (k)
                0: res.rate_x_comp = word;
                1: res.rate_y_comp = word;
                default: res.rate_z_comp = word;
            endcase
        end
    endtask

    function automatic burst_t burst_of(input int t, input int x, input int y, input int z);
        burst_t b;
        b.temp_raw   = t[15:0];
        b.rate_x_raw = x[15:0];
        b.rate_y_raw = y[15:0];
        b.rate_z_raw = z[15:0];
        return b;
    endfunction

    // Mostly full-range rates, with the extremes and zero now and then
    function automatic logic [15:0] pick_rate();
        logic [15:0] r;
        case ($urandom_range(9))
            0: r = 16'h8000;
            1: r = 16'h7FFF;
            2: r = 16'h0000;
            default: r = 16'($urandom());
        endcase
        return r;
    endfunction

    // Temperature mostly drifts slowly, sometimes jumps or hits a rail
    function automatic burst_t random_burst();
        burst_t b;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            temp_walk = $signed(16'($urandom()));
        end
        else if (pick < 20)
        begin
            temp_walk = pick[0] ? 32767 : -32768;
        end
        else
        begin
            temp_walk += $urandom_range(64) - 32;
            if (temp_walk > 32767)
            begin
                temp_walk = 32767;
            end
            if (temp_walk < -32768)
            begin
                temp_walk = -32768;
            end
        end
        b.temp_raw   = temp_walk[15:0];
        b.rate_x_raw = pick_rate();
        b.rate_y_raw = pick_rate();
        b.rate_z_raw = pick_rate();
        return b;
    endfunction

    task automatic write_coeff(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= CFG_SLOPE_Z)
        begin
            slope_coef[idx] = longint'($signed(val));
        end
        else if (idx <= CFG_INTERCEPT_Z)
        begin
            offset_coef[idx - CFG_INTERCEPT_X] = longint'($signed(val));
        end
    endtask

    // Load a full coefficient set, poke the spare indexes, then release the port
    task automatic program_coeffs(input logic [31:0] sx, input logic [31:0] sy,
                                  input logic [31:0] sz, input logic [31:0] ix,
                                  input logic [31:0] iy, input logic [31:0] iz);
        write_coeff(CFG_SLOPE_X, sx);
        write_coeff(CFG_SLOPE_Y, sy);
        write_coeff(CFG_SLOPE_Z, sz);
        write_coeff(CFG_INTERCEPT_X, ix);
        write_coeff(CFG_INTERCEPT_Y, iy);
        write_coeff(CFG_INTERCEPT_Z, iz);
        write_coeff(CFG_SPARE_6, $urandom());
        write_coeff(CFG_SPARE_7, $urandom());
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        coeff_sets++;
    endtask

    // Wait until every burst is taken and every result has come back
    task automatic drain();
        while (pending_bursts.size() != 0 || expected_comp.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
    endtask

    // Main sequence
    initial
    begin : stimulus
        int k;
        int p;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Extreme coefficients so that biases and rates clamp both ways
        program_coeffs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100);
        pending_bursts.push_back(burst_of(32767, 32767, -32768, -32768));
        pending_bursts.push_back(burst_of(-32768, -32768, 32767, 32767));
        pending_bursts.push_back(burst_of(0, 0, 0, 0));
        pending_bursts.push_back(burst_of(-1, -1, -1, -1));
        pending_bursts.push_back(burst_of(1, 1, 1, 1));
        for (k = 0; k < 10; k++)
        begin
            pending_bursts.push_back(burst_of(-32768, 21845, -21846,
                                              k[0] ? 32767 : -32768));
        end
        for (k = 0; k < 5; k++)
        begin
            pending_bursts.push_back(burst_of(32767, -21846, 21845, k));
        end
        drain();

        // Zero coefficients: pure scaling and Z negation
        program_coeffs('0, '0, '0, '0, '0, '0);
        for (k = 0; k < RAND_ITEMS; k++)
        begin
            pending_bursts.push_back(random_burst());
        end
        drain();

        // Opposite extremes
        program_coeffs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFF00_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        for (k = 0; k < RAND_ITEMS; k++)
        begin
            pending_bursts.push_back(random_burst());
        end
        drain();

        // Random coefficient sets
        for (p = 0; p < 2; p++)
        begin
            program_coeffs($urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom());
            for (k = 0; k < RAND_ITEMS; k++)
            begin
                pending_bursts.push_back(random_burst());
            end
            drain();
        end

        $display("Summary: %0d bursts over %0d coefficient sets, %0d bias refreshes,",
                 bursts_sent, coeff_sets, refresh_total);
        $display("         %0d clamped rate words, %0d field mismatches.",
                 saturated_total, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Take an accepted beat into the predictor
    always @(posedge clk)
    begin : burst_accept
        comp_t want;
        if (rst_n && burst_valid && !burst_stall)
        begin
            advance_compensation(burst, want);
            expected_comp.push_back(want);
            void'(pending_bursts.pop_front());
            bursts_sent++;
            burst_taken = 1'b1;
        end
    end

    // Offer the next beat, hold a stalled one, idle at random
    always @(negedge clk)
    begin : burst_drive
        bit quiet;
        quiet = (bursts_sent >= QUIET_LO && bursts_sent < QUIET_HI);
        if (!rst_n)
        begin
            burst_valid <= 1'b0;
        end
        else if (!burst_valid || burst_taken)
        begin
            if (pending_bursts.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                burst_valid <= 1'b1;
                burst       <= pending_bursts[0];
            end
            else
            begin
                burst_valid <= 1'b0;
            end
        end
        burst_taken = 1'b0;
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        comp_t want;
        if (rst_n && comp_valid && !comp_stall)
        begin
            results_seen++;
            if (expected_comp.size() == 0)
            begin
                $error("result beat with no burst outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_comp.pop_front();
                if (comp.filtered_temp !== want.filtered_temp)
                begin
                    $error("filtered_temp: expected %0d, got %0d",
                           want.filtered_temp, comp.filtered_temp);
                    mismatch_count++;
                end
                if (comp.rate_x_comp !== want.rate_x_comp)
                begin
                    $error("rate_x_comp: expected %0d, got %0d",
                           want.rate_x_comp, comp.rate_x_comp);
                    mismatch_count++;
                end
                if (comp.rate_y_comp !== want.rate_y_comp)
                begin
                    $error("rate_y_comp: expected %0d, got %0d",
                           want.rate_y_comp, comp.rate_y_comp);
                    mismatch_count++;
                end
                if (comp.rate_z_comp !== want.rate_z_comp)
                begin
                    $error("rate_z_comp: expected %0d, got %0d",
                           want.rate_z_comp, comp.rate_z_comp);
                    mismatch_count++;
                end
                if (comp.bias_refreshed !== want.bias_refreshed)
                begin
                    $error("bias_refreshed: expected %0d, got %0d",
                           want.bias_refreshed, comp.bias_refreshed);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver stall: one long hold-off to fill the pipeline, a stall-free window, otherwise random
    always @(negedge clk)
    begin : result_stall
        if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            comp_stall <= 1'b1;
            hold_left--;
        end
        else if (results_seen >= QUIET_LO && results_seen < QUIET_HI)
        begin
            comp_stall <= 1'b0;
        end
        else
        begin
            comp_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Abort if nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((burst_valid && !burst_stall) || (comp_valid && !comp_stall) || cfg_wr_en)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
